@@ rtl/core/cias_pkg.sv @@
`timescale 1ns / 1ps

package cias_pkg;

    // Table size and derived widths
    localparam int SLOT_COUNT = 5;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int IDX_EXT_W  = (SLOT_W > 3) ? SLOT_W : 3;
    localparam int MASK_EXT_W = (SLOT_COUNT > 5) ? SLOT_COUNT : 5;

    // Stream widths
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    // Serial remainder unit
    localparam int VAL_W     = 12;
    localparam int DIV_STEPS = VAL_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Operation codes
    localparam logic [1:0] OP_REG  = 2'd0;
    localparam logic [1:0] OP_FREE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Unit codes
    localparam logic [2:0] UNIT_SEC  = 3'd0;
    localparam logic [2:0] UNIT_MIN  = 3'd1;
    localparam logic [2:0] UNIT_HOUR = 3'd2;
    localparam logic [2:0] UNIT_DAY  = 3'd3;
    localparam logic [2:0] UNIT_MON  = 3'd4;
    localparam logic [2:0] UNIT_YEAR = 3'd5;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic slot_load;
        logic div_step;
        logic slot_done;
        logic push;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
        logic gate;
        logic div_last;
        logic slot_last;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/core/cias_ctrl.sv @@
`timescale 1ns / 1ps

module cias_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  cias_pkg::t_sts i_sts,
    output cias_pkg::t_cmd o_cmd
);
    import cias_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_SLOT = 6'b000100,
        S_DIV  = 6'b001000,
        S_NEXT = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.is_tick ? S_SLOT : S_DONE;
            end
            S_SLOT: begin
                o_cmd.slot_load = 1'b1;
                // skip the remainder when the slot cannot fire anyway
                n_state = i_sts.gate ? S_DIV : S_NEXT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.slot_done = 1'b1;
                n_state = i_sts.slot_last ? S_DONE : S_SLOT;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/core/cias_dp.sv @@
`timescale 1ns / 1ps

module cias_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [cias_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [cias_pkg::IN_USER_W-1:0]  i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [cias_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input  cias_pkg::t_cmd                 i_cmd,
    output cias_pkg::t_sts                 o_sts
);
    import cias_pkg::*;

    // Captured word
    logic [1:0]  r_op;
    logic [2:0]  r_unit;
    logic [11:0] r_interval;
    logic [3:0]  r_slot;
    logic [5:0]  r_sec;
    logic [5:0]  r_min;
    logic [4:0]  r_hour;
    logic [4:0]  r_dom;
    logic [3:0]  r_mon;
    logic [11:0] r_year;

    // Slot table
    logic [SLOT_COUNT-1:0] r_used;
    logic [2:0]            r_tab_unit [SLOT_COUNT];
    logic [VAL_W-1:0]      r_tab_int  [SLOT_COUNT];

    // Tick walk and remainder unit
    logic [SLOT_W-1:0]     r_idx;
    logic                  r_gate;
    logic [VAL_W-1:0]      r_dvd;
    logic [VAL_W-1:0]      r_div;
    logic [VAL_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_cnt;

    // Result and output stage
    logic [SLOT_COUNT-1:0] r_res_mask;
    logic                  r_res_ok;
    logic [SLOT_W-1:0]     r_res_idx;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                  free_found;
    logic [SLOT_W-1:0]     free_idx;
    logic                  free_in_range;
    logic [2:0]            cur_unit;
    logic [VAL_W-1:0]      cur_int;
    logic [VAL_W-1:0]      sel_val;
    logic                  sel_start;
    logic                  at_min;
    logic                  at_hour;
    logic                  at_day;
    logic                  at_mon;
    logic                  at_year;
    logic                  gate;
    logic [VAL_W:0]        trial;
    logic [VAL_W-1:0]      n_rem;
    logic [MASK_EXT_W-1:0] mask_ext;
    logic [IDX_EXT_W-1:0]  idx_ext;

    // Lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign free_in_range = ({1'b0, r_slot} < 5'(SLOT_COUNT));

    // Field and start condition for the slot being walked
    assign cur_unit = r_tab_unit[r_idx];
    assign cur_int  = r_tab_int[r_idx];
    assign at_min   = (r_sec == '0);
    assign at_hour  = at_min && (r_min == '0);
    assign at_day   = at_hour && (r_hour == '0);
    assign at_mon   = at_day && (r_dom == 5'd1);
    assign at_year  = at_mon && (r_mon == '0);

    always_comb begin
        unique case (cur_unit)
            UNIT_SEC: begin
                sel_val = VAL_W'(r_sec);
                sel_start = 1'b1;
            end
            UNIT_MIN: begin
                sel_val = VAL_W'(r_min);
                sel_start = at_min;
            end
            UNIT_HOUR: begin
                sel_val = VAL_W'(r_hour);
                sel_start = at_hour;
            end
            UNIT_DAY: begin
                sel_val = VAL_W'(r_dom);
                sel_start = at_day;
            end
            UNIT_MON: begin
                sel_val = VAL_W'(r_mon);
                sel_start = at_mon;
            end
            UNIT_YEAR: begin
                sel_val = r_year;
                sel_start = at_year;
            end
            default: begin
                sel_val = '0;
                sel_start = 1'b0;
            end
        endcase
    end

    assign gate = r_used[r_idx] && sel_start && (cur_int != '0);

    // One restoring step: remainder stays below the divisor
    assign trial = {r_rem, r_dvd[VAL_W-1]};
    assign n_rem = (trial >= {1'b0, r_div}) ? VAL_W'(trial - {1'b0, r_div}) : trial[VAL_W-1:0];

    // Status
    assign o_sts.is_tick   = (r_op == OP_TICK);
    assign o_sts.gate      = gate;
    assign o_sts.div_last  = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_sts.slot_last = (r_idx == SLOT_W'(SLOT_COUNT - 1));
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

    // Capture the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_s_tuser;
            r_unit     <= i_s_tdata[2:0];
            r_interval <= i_s_tdata[14:3];
            r_slot     <= i_s_tdata[18:15];
            r_sec      <= i_s_tdata[24:19];
            r_min      <= i_s_tdata[30:25];
            r_hour     <= i_s_tdata[35:31];
            r_dom      <= i_s_tdata[40:36];
            r_mon      <= i_s_tdata[44:41];
            r_year     <= i_s_tdata[56:45];
        end
    end

    // Occupancy flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.exec) begin
            if (r_op == OP_REG && free_found) begin
                r_used[free_idx] <= 1'b1;
            end else if (r_op == OP_FREE && free_in_range) begin
                r_used[r_slot[SLOT_W-1:0]] <= 1'b0;
            end
        end
    end

    // Slot settings
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_op == OP_REG && free_found) begin
            r_tab_unit[free_idx] <= r_unit;
            r_tab_int[free_idx]  <= r_interval;
        end
    end

    // Result registers and slot walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_mask <= '0;
            r_res_ok   <= (r_op == OP_REG) && free_found;
            r_res_idx  <= (r_op == OP_REG && free_found) ? free_idx : '0;
            r_idx      <= '0;
        end else if (i_cmd.slot_done) begin
            if (r_gate && r_rem == '0) begin
                r_res_mask[r_idx] <= 1'b1;
            end
            if (!o_sts.slot_last) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Remainder unit
    always_ff @(posedge i_clk) begin
        if (i_cmd.slot_load) begin
            r_gate <= gate;
            r_dvd  <= sel_val;
            r_div  <= cur_int;
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[VAL_W-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Output stage
    assign mask_ext = MASK_EXT_W'(r_res_mask);
    assign idx_ext  = IDX_EXT_W'(r_res_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_data <= {7'b0, idx_ext[2:0], r_res_ok, mask_ext[4:0]};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

@@ rtl/core/calendar_interval_alarm_slots.sv @@
`timescale 1ns / 1ps

// Alarm slot table driven by a calendar tick. A register word (tuser 0) claims
// the lowest free slot and answers with reg_ok and reg_slot; a free word
// (tuser 1) releases a slot; a tick word (tuser 2) answers with the mask of
// slots that fire at that time. Every word gives exactly one result word.
// Register and free words pass from acceptance through the exec and done
// states into the output register. A tick walks the slots one at a time,
// loading and closing each slot; for an occupied slot with a nonzero interval
// whose start condition holds, a shared bit-serial remainder unit divides the
// selected time field by the slot interval in between. The next word is
// accepted once a result is in the output register, even while that result
// waits to be taken.

module calendar_interval_alarm_slots (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // op
    input  logic [cias_pkg::IN_USER_W-1:0]  i_s_tuser,
    // unit, interval, slot, second, minute, hour, day_of_month, month, year
    input  logic [cias_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // fired_mask, reg_ok, reg_slot
    output logic [cias_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import cias_pkg::*;

    t_cmd cmd;
    t_sts sts;

    cias_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cias_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule

@@ rtl/core/cias_chk.sv @@
`timescale 1ns / 1ps

module cias_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [cias_pkg::IN_USER_W-1:0]  i_s_tuser,
    input logic [cias_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [cias_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import cias_pkg::*;

    // Reset empties the output stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed under stall");

    // One word at a time: busy right after acceptance
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second word accepted while busy");

    // Failed or non-register result carries slot zero
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[5] |-> o_m_tdata[8:6] == 3'd0)
        else $error("reg_slot set without reg_ok");

    // A register result never carries a fire mask
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[5] |-> o_m_tdata[4:0] == 5'd0)
        else $error("reg_ok and fired_mask together");

endmodule

bind calendar_interval_alarm_slots cias_chk u_chk (.*);

@@ sim/calendar_interval_alarm_slots_tb.sv @@
`timescale 1ns / 1ps

// Stream-level test of the alarm slot table: a directed pass over the special
// cases, random traffic under several idling mixes, and a long output hold.
// Every accepted input word is run through a local table model and the
// expected result word is queued; result words are checked in order.

module calendar_interval_alarm_slots_tb;
    import cias_pkg::*;

    // Op code with no effect
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [4:0] fired_mask;
        logic       reg_ok;
        logic [2:0] reg_slot;
    } t_alarm_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    // op
    logic [IN_USER_W-1:0]  i_s_tuser;
    // unit, interval, slot, second, minute, hour, day_of_month, month, year
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    // fired_mask, reg_ok, reg_slot
    logic [OUT_DATA_W-1:0] o_m_tdata;

    // Local copy of the slot table
    logic        alarm_used   [SLOT_COUNT];
    logic [2:0]  alarm_unit   [SLOT_COUNT];
    logic [11:0] alarm_period [SLOT_COUNT];

    t_alarm_result pending_results[$];
    int mismatch_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int stall_request = 0;
    int hold_left = 0;

    calendar_interval_alarm_slots dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run-length guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("FAIL calendar_interval_alarm_slots");
            $finish;
        end
    end

    function automatic logic [63:0] pack_fields(
        input logic [2:0] unit, input logic [11:0] period, input logic [3:0] slot,
        input logic [5:0] sec, input logic [5:0] min, input logic [4:0] hr,
        input logic [4:0] day, input logic [3:0] mon, input logic [11:0] yr);
        return {7'd0, yr, mon, day, hr, min, sec, slot, period, unit};
    endfunction

    function automatic logic [63:0] reg_fields(input logic [2:0] unit,
                                               input logic [11:0] period);
        return pack_fields(unit, period, 4'd0, 6'd0, 6'd0, 5'd0, 5'd0, 4'd0, 12'd0);
    endfunction

    function automatic logic [63:0] free_fields(input logic [3:0] slot);
        return pack_fields(3'd0, 12'd0, slot, 6'd0, 6'd0, 5'd0, 5'd0, 4'd0, 12'd0);
    endfunction

    function automatic logic [63:0] tick_fields(
        input logic [5:0] sec, input logic [5:0] min, input logic [4:0] hr,
        input logic [4:0] day, input logic [3:0] mon, input logic [11:0] yr);
        return pack_fields(3'd0, 12'd0, 4'd0, sec, min, hr, day, mon, yr);
    endfunction

    function automatic logic period_divides(input logic [11:0] value,
                                            input logic [11:0] period);
        if (period == 12'd0)
            return 1'b0;
        return (value % period) == 12'd0;
    endfunction

    // Table model: applies one word and gives the result word it causes
    function automatic t_alarm_result predict_alarm_result(input logic [1:0] op,
                                                           input logic [63:0] data);
        t_alarm_result res;
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hr;
        logic [4:0]  day;
        logic [3:0]  mon;
        logic [11:0] yr;
        logic [3:0]  slot;
        logic        at_min, at_hr, at_day, at_mon, at_yr, hit;
        res  = '0;
        slot = data[18:15];
        sec  = data[24:19];
        min  = data[30:25];
        hr   = data[35:31];
        day  = data[40:36];
        mon  = data[44:41];
        yr   = data[56:45];
        at_min = (sec == 6'd0);
        at_hr  = at_min && (min == 6'd0);
        at_day = at_hr && (hr == 5'd0);
        at_mon = at_day && (day == 5'd1);
        at_yr  = at_mon && (mon == 4'd0);
        case (op)
            OP_REG: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!alarm_used[i] && !res.reg_ok) begin
                        alarm_used[i]   = 1'b1;
                        alarm_unit[i]   = data[2:0];
                        alarm_period[i] = data[14:3];
                        res.reg_ok      = 1'b1;
                        res.reg_slot    = 3'(i);
                    end
                end
            end
            OP_FREE: begin
                if (int'(slot) < SLOT_COUNT)
                    alarm_used[slot] = 1'b0;
            end
            OP_TICK: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    case (alarm_unit[i])
                        UNIT_SEC:  hit = period_divides(12'(sec), alarm_period[i]);
                        UNIT_MIN:  hit = at_min && period_divides(12'(min), alarm_period[i]);
                        UNIT_HOUR: hit = at_hr && period_divides(12'(hr), alarm_period[i]);
                        UNIT_DAY:  hit = at_day && period_divides(12'(day), alarm_period[i]);
                        UNIT_MON:  hit = at_mon && period_divides(12'(mon), alarm_period[i]);
                        UNIT_YEAR: hit = at_yr && period_divides(yr, alarm_period[i]);
                        default:   hit = 1'b0;
                    endcase
                    if (alarm_used[i] && hit && i < 5)
                        res.fired_mask[i] = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s expected %0d got %0d",
                     cycle_count, what, want, got);
        mismatch_count++;
    endtask

    // Predict on every accepted input word
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            pending_results.push_back(predict_alarm_result(i_s_tuser, i_s_tdata));
    end

    // Check every accepted result word against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_alarm_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with none pending", 0, int'(o_m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[4:0] != want.fired_mask)
                    report_mismatch("fired_mask", want.fired_mask, o_m_tdata[4:0]);
                if (o_m_tdata[5] != want.reg_ok)
                    report_mismatch("reg_ok", want.reg_ok, o_m_tdata[5]);
                if (o_m_tdata[8:6] != want.reg_slot)
                    report_mismatch("reg_slot", want.reg_slot, o_m_tdata[8:6]);
            end
        end
    end

    // Result side: random stalls, plus long holds on request
    always @(posedge i_clk) begin
        if (stall_request > 0) begin
            hold_left = stall_request;
            stall_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one word, with random idle cycles first, and wait for acceptance
    task automatic send_word(input logic [1:0] op, input logic [63:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= data;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
    endtask

    // Random word: ticks are the largest share, most aligned to a unit boundary, with noise in idle fields
    task automatic send_random_word();
        int pick;
        int level;
        logic [2:0]  unit;
        logic [11:0] period;
        logic [3:0]  slot;
        logic [5:0]  sec, min;
        logic [4:0]  hr, day;
        logic [3:0]  mon;
        logic [11:0] yr;
        logic [1:0]  op;
        pick   = $urandom_range(99);
        unit   = 3'($urandom_range(7));
        period = 12'($urandom_range(4095));
        slot   = 4'($urandom_range(15));
        sec    = 6'($urandom_range(63));
        min    = 6'($urandom_range(63));
        hr     = 5'($urandom_range(31));
        day    = 5'($urandom_range(31));
        mon    = 4'($urandom_range(15));
        yr     = 12'($urandom_range(4095));
        if (pick < 40) begin
            op = OP_TICK;
            if ($urandom_range(9) != 0) begin
                level = $urandom_range(5);
                sec = (level > 0) ? 6'd0 : 6'($urandom_range(60));
                min = (level > 1) ? 6'd0 : 6'($urandom_range(59));
                hr  = (level > 2) ? 5'd0 : 5'($urandom_range(23));
                day = (level > 3) ? 5'd1 : 5'($urandom_range(31, 1));
                mon = (level > 4) ? 4'd0 : 4'($urandom_range(11));
                if ($urandom_range(1) == 0)
                    yr = 12'($urandom_range(48));
            end
        end else if (pick < 65) begin
            op = OP_REG;
            if ($urandom_range(9) != 0)
                unit = 3'($urandom_range(5));
            case ($urandom_range(9))
                0:       period = 12'd0;
                1, 2:    ;
                default: period = 12'($urandom_range(12, 1));
            endcase
        end else if (pick < 95) begin
            op = OP_FREE;
            if ($urandom_range(6) != 0)
                slot = 4'($urandom_range(SLOT_COUNT - 1));
        end else begin
            op = OP_NONE;
        end
        send_word(op, pack_fields(unit, period, slot, sec, min, hr, day, mon, yr));
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // tick on an empty table
        send_word(OP_TICK, tick_fields(6'd0, 6'd0, 5'd0, 5'd1, 4'd0, 12'd0));
        // fill the table, zero interval in the hour slot
        send_word(OP_REG, reg_fields(UNIT_SEC, 12'd1));
        send_word(OP_REG, reg_fields(UNIT_MIN, 12'd2));
        send_word(OP_REG, reg_fields(UNIT_HOUR, 12'd0));
        send_word(OP_REG, reg_fields(UNIT_DAY, 12'd3));
        send_word(OP_REG, reg_fields(UNIT_MON, 12'd4));
        // table full
        send_word(OP_REG, reg_fields(UNIT_YEAR, 12'd5));
        send_word(OP_TICK, tick_fields(6'd0, 6'd0, 5'd0, 5'd1, 4'd0, 12'd0));
        // free, free again, and out-of-range frees
        send_word(OP_FREE, free_fields(4'd2));
        send_word(OP_FREE, free_fields(4'd2));
        send_word(OP_FREE, free_fields(4'd15));
        send_word(OP_FREE, free_fields(4'(SLOT_COUNT)));
        // yearly slot with the widest interval
        send_word(OP_REG, reg_fields(UNIT_YEAR, 12'd4095));
        send_word(OP_TICK, tick_fields(6'd0, 6'd0, 5'd0, 5'd1, 4'd0, 12'd0));
        send_word(OP_TICK, tick_fields(6'd0, 6'd0, 5'd0, 5'd1, 4'd0, 12'd4095));
        // op with no effect, all field bits set
        send_word(OP_NONE, {7'd0, {57{1'b1}}});
        // unused unit codes never fire
        send_word(OP_FREE, free_fields(4'd2));
        send_word(OP_REG, reg_fields(3'd7, 12'd1));
        send_word(OP_TICK, tick_fields(6'd63, 6'd63, 5'd31, 5'd31, 4'd15, 12'd4095));
        send_word(OP_FREE, free_fields(4'd3));
        send_word(OP_REG, reg_fields(3'd6, 12'd1));
        send_word(OP_TICK, tick_fields(6'd0, 6'd0, 5'd0, 5'd1, 4'd0, 12'd0));
        // leap second, far-off year
        send_word(OP_TICK, tick_fields(6'd60, 6'd0, 5'd0, 5'd1, 4'd0, 12'd2048));
        // fields out of range at the day boundary
        send_word(OP_TICK, tick_fields(6'd0, 6'd0, 5'd0, 5'd0, 4'd12, 12'd0));
    endtask

    task automatic test_random_phase(input int count, input int idle_pct,
                                     input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_random_word();
    endtask

    // Hold the result side for a long stretch while the sender keeps offering
    task automatic test_output_hold();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stall_request  = 400;
        repeat (30)
            send_random_word();
    endtask

    initial begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            alarm_used[i]   = 1'b0;
            alarm_unit[i]   = 3'd0;
            alarm_period[i] = 12'd0;
        end
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tuser  = '0;
        i_s_tdata  = '0;
        i_m_tready = 1'b0;
        repeat (12)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(200, 0, 0);
        test_random_phase(200, 68, 0);
        test_random_phase(200, 0, 68);
        test_random_phase(200, 14, 14);
        test_output_hold();
        i_s_tvalid <= 1'b0;

        // drain, then allow for a slow tick still in flight
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (100)
            @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS calendar_interval_alarm_slots");
        else
            $display("FAIL calendar_interval_alarm_slots");
        $finish;
    end

endmodule
